// File: rtl/chp_pkg.sv
// Package: types, constants and tables shared by the chroma peak-sum block.
`timescale 1ns / 1ps
package chp_pkg;

  localparam int FftSizeDef      = 8192;
  localparam int NumOctavesDef   = 2;
  localparam int NumHarmonicsDef = 2;

  localparam int NUM_NOTES  = 12;
  localparam int MAG_W      = 24;
  localparam int BPH_W      = 24;
  localparam int HW_W       = 4;
  localparam int ROM_W      = 24;
  localparam int PROD1_W    = ROM_W + BPH_W;
  localparam int CHROMA_W   = 26;
  localparam int ACC_W      = 32;
  localparam int K_W        = 23;
  localparam int O_W        = 3;
  localparam int H_W        = 3;
  localparam int OH_W       = O_W + H_W;
  localparam int ROOT_W     = 48;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int STEP_W     = 6;
  localparam int ROOT1_STEPS = 48;
  localparam int ROOT2_STEPS = 24;

  localparam logic [BPH_W-1:0]    BPH_RESET  = 24'd48696;
  localparam logic [HW_W-1:0]     HW_RESET   = 4'd2;
  localparam logic [CHROMA_W-1:0] CHROMA_MAX = {CHROMA_W{1'b1}};
  localparam logic [ACC_W-1:0]    ROUND_HALF = 32'd6;
  localparam logic [31:0]         RECIP3     = 32'hAAAAAAAB;
  localparam logic [3:0]          LAST_NOTE  = 4'd11;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;
  localparam logic REG_BPH     = 1'b0;
  localparam logic REG_HW      = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [12:0]        bin_index;
    logic signed [31:0] bin_real;
    logic signed [31:0] bin_imag;
  } chp_req_t;

  typedef struct packed {
    logic [3:0]          note_index;
    logic [CHROMA_W-1:0] chroma_value;
    logic                last_note;
  } chp_res_t;

  typedef struct packed {
    logic           latch;
    logic           sq;
    logic           prep;
    logic           step;
    logic           mid;
    logic           wr;
    logic           note;
    logic           mul2;
    logic           ctr;
    logic           scan;
    logic           acc;
    logic           div;
    logic           emit;
    logic           last;
    logic [3:0]     n;
    logic [O_W-1:0] o;
    logic [H_W-1:0] h;
  } chp_ctl_t;

  function automatic logic [ROM_W-1:0] note_rom(input logic [3:0] n);
    logic [ROM_W-1:0] r;
    case (n)
      4'd0:    r = 24'd8572947;
      4'd1:    r = 24'd9082720;
      4'd2:    r = 24'd9622807;
      4'd3:    r = 24'd10195009;
      4'd4:    r = 24'd10801236;
      4'd5:    r = 24'd11443511;
      4'd6:    r = 24'd12123977;
      4'd7:    r = 24'd12844906;
      4'd8:    r = 24'd13608704;
      4'd9:    r = 24'd14417920;
      4'd10:   r = 24'd15275254;
      4'd11:   r = 24'd16183568;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] harm_weight(input logic [H_W-1:0] h);
    logic [3:0] w;
    case (h)
      3'd1:    w = 4'd12;
      3'd2:    w = 4'd6;
      3'd3:    w = 4'd4;
      3'd4:    w = 4'd3;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/chroma_harmonic_peak_sum.sv
// Top level: chromagram by harmonic peak picking over a stored spectrum.
// A load request keeps busy high through two bit-serial square roots.
// A compute request runs per note a peak search for each octave/harmonic pair over
// 2*w*h entries, w the search half width; the search reads one store entry a cycle.
// Results leave as 12 one-cycle strobes, the receiver cannot stall them.
// Reset restores the register defaults; the store holds no data until loaded.
`timescale 1ns / 1ps
module chroma_harmonic_peak_sum #(
  parameter int FFT_SIZE      = chp_pkg::FftSizeDef,
  parameter int NUM_OCTAVES   = chp_pkg::NumOctavesDef,
  parameter int NUM_HARMONICS = chp_pkg::NumHarmonicsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  chp_pkg::chp_req_t req_i,
  output logic              result_valid_o,
  output chp_pkg::chp_res_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import chp_pkg::*;

  logic [BPH_W-1:0] bph_q;
  logic [HW_W-1:0]  hw_q;
  logic             busy_w, scan_done;
  chp_ctl_t         ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bph_q <= BPH_RESET;
      hw_q  <= HW_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_BPH: bph_q <= pwdata[BPH_W-1:0];
        REG_HW:  hw_q  <= pwdata[HW_W-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HW) ? 32'(hw_q) : 32'(bph_q);
  assign pready = 1'b1;
  assign busy   = busy_w;

  chp_ctrl #(
    .NUM_OCTAVES  (NUM_OCTAVES),
    .NUM_HARMONICS(NUM_HARMONICS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (req_i.cmd),
    .scan_done_i(scan_done),
    .busy_o     (busy_w),
    .ctl_o      (ctl)
  );

  chp_datapath #(
    .FFT_SIZE(FFT_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .req_i         (req_i),
    .bph_i         (bph_q),
    .hw_i          (hw_q),
    .scan_done_o   (scan_done),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// File: rtl/chp_ctrl.sv
// Controller: sequences bin loads and the per-note harmonic peak search.
`timescale 1ns / 1ps
module chp_ctrl #(
  parameter int NUM_OCTAVES   = chp_pkg::NumOctavesDef,
  parameter int NUM_HARMONICS = chp_pkg::NumHarmonicsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cmd_i,
  input  logic              scan_done_i,
  output logic              busy_o,
  output chp_pkg::chp_ctl_t ctl_o
);
  import chp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_PREP, S_ROOT1, S_MID, S_ROOT2, S_WR,
    S_NOTE, S_MUL2, S_CTR, S_SCAN, S_DRAIN, S_ACC, S_DIV, S_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic [3:0]        n_q;
  logic [O_W-1:0]    o_q;
  logic [H_W-1:0]    h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      o_q     <= '0;
      h_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            n_q     <= '0;
            state_q <= (cmd_i == CMD_LOAD) ? S_SQ : S_NOTE;
          end
        end
        S_SQ:   state_q <= S_PREP;
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_ROOT1;
        end
        S_ROOT1: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(ROOT1_STEPS - 1)) state_q <= S_MID;
        end
        S_MID: begin
          cnt_q   <= '0;
          state_q <= S_ROOT2;
        end
        S_ROOT2: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(ROOT2_STEPS - 1)) state_q <= S_WR;
        end
        S_WR: state_q <= S_IDLE;
        S_NOTE: begin
          o_q     <= O_W'(1);
          h_q     <= H_W'(1);
          state_q <= S_MUL2;
        end
        S_MUL2:  state_q <= S_CTR;
        S_CTR:   state_q <= S_SCAN;
        S_SCAN:  if (scan_done_i) state_q <= S_DRAIN;
        S_DRAIN: state_q <= S_ACC;
        S_ACC: begin
          if (h_q != H_W'(NUM_HARMONICS)) begin
            h_q     <= h_q + 1'b1;
            state_q <= S_MUL2;
          end else if (o_q != O_W'(NUM_OCTAVES)) begin
            o_q     <= o_q + 1'b1;
            h_q     <= H_W'(1);
            state_q <= S_MUL2;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: state_q <= S_EMIT;
        S_EMIT: begin
          if (n_q == LAST_NOTE) begin
            state_q <= S_IDLE;
          end else begin
            n_q     <= n_q + 1'b1;
            state_q <= S_NOTE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o       = '0;
    ctl_o.latch = (state_q == S_IDLE) && start_i;
    ctl_o.sq    = (state_q == S_SQ);
    ctl_o.prep  = (state_q == S_PREP);
    ctl_o.step  = (state_q == S_ROOT1) || (state_q == S_ROOT2);
    ctl_o.mid   = (state_q == S_MID);
    ctl_o.wr    = (state_q == S_WR);
    ctl_o.note  = (state_q == S_NOTE);
    ctl_o.mul2  = (state_q == S_MUL2);
    ctl_o.ctr   = (state_q == S_CTR);
    ctl_o.scan  = (state_q == S_SCAN) && !scan_done_i;
    ctl_o.acc   = (state_q == S_ACC);
    ctl_o.div   = (state_q == S_DIV);
    ctl_o.emit  = (state_q == S_EMIT);
    ctl_o.last  = (n_q == LAST_NOTE);
    ctl_o.n     = n_q;
    ctl_o.o     = o_q;
    ctl_o.h     = h_q;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: rtl/chp_datapath.sv
// Datapath: magnitude root unit, spectrum store, peak search and chroma sum.
`timescale 1ns / 1ps
module chp_datapath #(
  parameter int FFT_SIZE = chp_pkg::FftSizeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chp_pkg::chp_ctl_t         ctl_i,
  input  chp_pkg::chp_req_t         req_i,
  input  logic [chp_pkg::BPH_W-1:0] bph_i,
  input  logic [chp_pkg::HW_W-1:0]  hw_i,
  output logic                      scan_done_o,
  output logic                      result_valid_o,
  output chp_pkg::chp_res_t         result_o
);
  import chp_pkg::*;

  localparam int DEPTH   = FFT_SIZE / 2 + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int P2_W    = PROD1_W + OH_W;
  localparam int X_W     = ACC_W - 1;
  localparam int Q_W     = X_W + 32;

  logic [31:0]          ar_q, ai_q;
  logic                 idx_ok_q;
  logic [ADDR_W-1:0]    waddr_q;
  logic [63:0]          asq_q, bsq_q;
  logic [RAD_W-1:0]     rad_q;
  logic [ROOT_W-1:0]    root_q;
  logic [REM_W-1:0]     rem_q;
  logic [MAG_W-1:0]     mem [DEPTH];
  logic [MAG_W-1:0]     rdata_q;
  logic                 rdv_q;
  logic [PROD1_W-1:0]   prod1_q;
  logic [P2_W-1:0]      p2_q;
  logic signed [K_W-1:0] k_q, end_q;
  logic [MAG_W-1:0]     peak_q;
  logic [ACC_W-1:0]     acc_q;
  logic [Q_W-1:0]       q_q;
  logic                 valid_q;
  chp_res_t             res_q;

  logic [REM_W-1:0]      rem_n, trial;
  logic [P2_W:0]         rsum;
  logic signed [K_W-1:0] centre, span;
  logic [ACC_W:0]        acc_rnd;
  logic [X_W-1:0]        x;
  logic [Q_W-33-1:0]     quot;
  logic [CHROMA_W-1:0]   sat;
  logic                  in_range;
  logic [ADDR_W-1:0]     raddr;

  always_comb begin
    rem_n    = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial    = REM_W'({root_q, 2'b01});
    rsum     = {1'b0, p2_q} + (P2_W+1)'(64'h80000000);
    centre   = K_W'(rsum >> 32);
    span     = K_W'(hw_i) * K_W'(ctl_i.h);
    acc_rnd  = {1'b0, acc_q} + (ACC_W+1)'(ROUND_HALF);
    x        = X_W'(acc_rnd >> 2);
    quot     = (Q_W-33)'(q_q >> 33);
    sat      = (quot > (Q_W-33)'(CHROMA_MAX)) ? CHROMA_MAX : CHROMA_W'(quot);
    in_range = (k_q >= 0) && (k_q < $signed(K_W'(DEPTH)));
    raddr    = ADDR_W'(k_q);
  end

  assign scan_done_o = (k_q >= end_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      ar_q     <= req_i.bin_real[31] ? 32'(-req_i.bin_real) : 32'(req_i.bin_real);
      ai_q     <= req_i.bin_imag[31] ? 32'(-req_i.bin_imag) : 32'(req_i.bin_imag);
      idx_ok_q <= (32'(req_i.bin_index) < 32'(DEPTH));
      waddr_q  <= ADDR_W'(req_i.bin_index);
    end
    if (ctl_i.sq) begin
      asq_q <= ar_q * ar_q;
      bsq_q <= ai_q * ai_q;
    end
    if (ctl_i.prep) begin
      rad_q  <= {asq_q + bsq_q, 32'b0};
      root_q <= '0;
      rem_q  <= '0;
    end else if (ctl_i.mid) begin
      rad_q  <= {root_q, {(RAD_W-ROOT_W){1'b0}}};
      root_q <= '0;
      rem_q  <= '0;
    end else if (ctl_i.step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (ctl_i.note) begin
      prod1_q <= note_rom(ctl_i.n) * bph_i;
      acc_q   <= '0;
    end else if (ctl_i.acc) begin
      acc_q <= acc_q + ACC_W'(peak_q) * ACC_W'(harm_weight(ctl_i.h));
    end
    if (ctl_i.mul2) p2_q <= prod1_q * (ctl_i.o * ctl_i.h);
    if (ctl_i.ctr) begin
      k_q    <= centre - span;
      end_q  <= centre + span;
      peak_q <= '0;
    end else begin
      if (ctl_i.scan) k_q <= k_q + 1'b1;
      if (rdv_q && (rdata_q > peak_q)) peak_q <= rdata_q;
    end
    if (ctl_i.div) q_q <= x * RECIP3;
    if (ctl_i.emit) begin
      res_q.note_index   <= ctl_i.n;
      res_q.chroma_value <= sat;
      res_q.last_note    <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && idx_ok_q) mem[waddr_q] <= root_q[MAG_W-1:0];
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      rdv_q   <= ctl_i.scan && in_range;
      valid_q <= ctl_i.emit;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
